>>> sv/sacl_pkg.sv
// sacl_pkg: shared types and constants for the LRU cache tag store.
// No dependencies; the interfaces, sacl_mod, the top and the testbench refer to it by scoped names.
`timescale 1ns / 1ps

package sacl_pkg;

  // default geometry
  localparam int WAYS_DEF = 4;
  localparam int SETS_DEF = 64;

  // fixed field widths
  localparam int ADDR_W     = 32;
  localparam int WAY_NUM_W  = 2;
  localparam int OUTCOME_W  = 3;
  localparam int SET_IDX_W  = 6;
  localparam int TIME_W     = 32;
  localparam int WAYS_CFG_W = 3;
  localparam int SETS_CFG_W = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // modulo unit retires this many dividend bits per cycle
  localparam int DIV_STEP_BITS = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REG_WAYS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_SETS = 8'd1;

  // reset values of the registers
  localparam logic [WAYS_CFG_W-1:0] WAYS_CFG_RST = 3'd4;
  localparam logic [SETS_CFG_W-1:0] SETS_CFG_RST = 7'd64;

  // item kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INVAL  = 1'b1;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_HIT      = 3'd0,
    OC_FILL     = 3'd1,
    OC_REPLACE  = 3'd2,
    OC_INVAL    = 3'd3,
    OC_IGNORED  = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_UPDATE,
    ST_INVAL,
    ST_DONE
  } state_t;

  // request to the modulo unit
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
  } mod_req_t;

endpackage

>>> sv/sacl_in_if.sv
// sacl_in_if: input channel of the tag store (lookup / invalidate words).
// Depends on sacl_pkg for field widths.
`timescale 1ns / 1ps

interface sacl_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [sacl_pkg::ADDR_W-1:0]    address;
  logic [sacl_pkg::ADDR_W-1:0]    block_number;
  logic [sacl_pkg::WAY_NUM_W-1:0] way_number;

  modport source(output valid, kind, address, block_number, way_number, input ready);
  modport sink(input valid, kind, address, block_number, way_number, output ready);
endinterface

>>> sv/sacl_out_if.sv
// sacl_out_if: result channel of the tag store.
// Depends on sacl_pkg for field widths.
`timescale 1ns / 1ps

interface sacl_out_if;
  logic                           valid;
  logic                           ready;
  logic [sacl_pkg::OUTCOME_W-1:0] outcome;
  logic [sacl_pkg::WAY_NUM_W-1:0] way_touched;
  logic [sacl_pkg::SET_IDX_W-1:0] set_index;

  modport source(output valid, outcome, way_touched, set_index, input ready);
  modport sink(input valid, outcome, way_touched, set_index, output ready);
endinterface

>>> sv/sacl_cfg_if.sv
// sacl_cfg_if: register write channel (index + data).
// Depends on sacl_pkg for field widths.
`timescale 1ns / 1ps

interface sacl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sacl_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [sacl_pkg::CFG_DATA_W-1:0] wr_data;

  modport source(output valid, reg_index, wr_data, input ready);
  modport sink(input valid, reg_index, wr_data, output ready);
endinterface

>>> sv/set_assoc_cache_lru_tags.sv
// set_assoc_cache_lru_tags: set-associative tag store with timestamp LRU replacement.
// Depends on sacl_pkg, sacl_in_if, sacl_out_if, sacl_cfg_if, sacl_mod and sacl_ram.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   kind, address, block_number, way_number
//   out_ch   out  valid/ready   outcome, way_touched, set_index
//   cfg_ch   in   valid/ready   reg_index, wr_data (always ready)
//
// A lookup passes through the modulo state, a scan of the ways in use, an update state and
// a result state; an invalidate passes through the modulo, invalidate and result states.
// After each word the sequencer returns to idle, where the next word is accepted. The
// 2-bit-per-cycle modulo unit and the single tag/stamp RAM read port, one way per cycle, set the pace.
// One word is in flight; in_ch.ready is high only while idle. The result register frees
// the sequencer unless a previous result still stalls on out_ch.ready.
// Synchronous reset clears valid bits and sets the time counter to one; no clearing pass.
`timescale 1ns / 1ps

module set_assoc_cache_lru_tags #(
  parameter int WAYS = sacl_pkg::WAYS_DEF,
  parameter int SETS = sacl_pkg::SETS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sacl_in_if.sink    in_ch,
  sacl_out_if.source out_ch,
  sacl_cfg_if.sink   cfg_ch
);

  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_CNT_W = $clog2(WAYS + 1);
  localparam int DV_W      = $clog2(SETS + 1);
  localparam int RAM_AW    = SET_W + WAY_W;
  localparam int RAM_DEPTH = 2 ** RAM_AW;
  localparam int RAM_W     = sacl_pkg::ADDR_W + sacl_pkg::TIME_W;

  // configuration
  logic [sacl_pkg::WAYS_CFG_W-1:0] ways_cfg_r;
  logic [sacl_pkg::SETS_CFG_W-1:0] sets_cfg_r;
  logic [WAY_CNT_W-1:0]            eff_ways;
  logic [DV_W-1:0]                 eff_sets;

  // sequencer
  sacl_pkg::state_t state_r, state_nxt;
  logic in_acc;
  logic cfg_acc;
  logic ram_we;
  logic out_load;
  logic scan_last;

  // item and working registers
  logic                           kind_r;
  logic [sacl_pkg::ADDR_W-1:0]    addr_r;
  logic [sacl_pkg::WAY_NUM_W-1:0] way_num_r;
  logic [SET_W-1:0]               set_r;
  logic [sacl_pkg::TIME_W-1:0]    time_r;
  logic [WAYS-1:0]                valid_r [SETS];

  logic [WAY_CNT_W-1:0]        scan_cnt_r;
  logic                        hit_r;
  logic [WAY_W-1:0]            hit_way_r;
  logic                        inv_found_r;
  logic [WAY_W-1:0]            inv_way_r;
  logic [WAY_W-1:0]            best_way_r;
  logic [sacl_pkg::TIME_W-1:0] best_stamp_r;

  logic [WAY_W-1:0]            chk_way;
  logic                        chk_valid;
  logic [sacl_pkg::ADDR_W-1:0] rd_tag;
  logic [sacl_pkg::TIME_W-1:0] rd_stamp;
  logic [WAY_W-1:0]            upd_way;
  sacl_pkg::outcome_t          upd_outcome;
  logic                        inval_ok;

  // result
  sacl_pkg::outcome_t             res_outcome_r;
  logic [sacl_pkg::WAY_NUM_W-1:0] res_way_r;
  logic                           out_valid_r;
  sacl_pkg::outcome_t             out_outcome_r;
  logic [sacl_pkg::WAY_NUM_W-1:0] out_way_r;
  logic [sacl_pkg::SET_IDX_W-1:0] out_set_r;

  // shared units
  sacl_pkg::mod_req_t mod_req;
  logic               mod_done;
  logic [SET_W-1:0]   mod_rem;
  logic [RAM_W-1:0]   ram_rdata;

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_cfg_r <= sacl_pkg::WAYS_CFG_RST;
      sets_cfg_r <= sacl_pkg::SETS_CFG_RST;
    end else if (cfg_acc) begin
      unique case (cfg_ch.reg_index)
        sacl_pkg::CFG_REG_WAYS: ways_cfg_r <= cfg_ch.wr_data[sacl_pkg::WAYS_CFG_W-1:0];
        sacl_pkg::CFG_REG_SETS: sets_cfg_r <= cfg_ch.wr_data[sacl_pkg::SETS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range register values clamp to 1 .. WAYS / SETS
  always_comb begin
    priority if (ways_cfg_r == '0) begin
      eff_ways = WAY_CNT_W'(1);
    end else if (32'(ways_cfg_r) > 32'(WAYS)) begin
      eff_ways = WAY_CNT_W'(WAYS);
    end else begin
      eff_ways = WAY_CNT_W'(ways_cfg_r);
    end
    priority if (sets_cfg_r == '0) begin
      eff_sets = DV_W'(1);
    end else if (32'(sets_cfg_r) > 32'(SETS)) begin
      eff_sets = DV_W'(SETS);
    end else begin
      eff_sets = DV_W'(sets_cfg_r);
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign scan_last = (scan_cnt_r == eff_ways);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sacl_pkg::ST_IDLE:   if (in_ch.valid) state_nxt = sacl_pkg::ST_DIV;
      sacl_pkg::ST_DIV: begin
        if (mod_done) begin
          state_nxt = (kind_r == sacl_pkg::KIND_INVAL) ? sacl_pkg::ST_INVAL
                                                       : sacl_pkg::ST_SCAN;
        end
      end
      sacl_pkg::ST_SCAN:   if (scan_last) state_nxt = sacl_pkg::ST_UPDATE;
      sacl_pkg::ST_UPDATE: state_nxt = sacl_pkg::ST_DONE;
      sacl_pkg::ST_INVAL:  state_nxt = sacl_pkg::ST_DONE;
      sacl_pkg::ST_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = sacl_pkg::ST_IDLE;
      default:             state_nxt = sacl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == sacl_pkg::ST_IDLE);
    ram_we      = (state_r == sacl_pkg::ST_UPDATE);
    out_load    = (state_r == sacl_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);
  end

  assign in_acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- modulo
  assign mod_req.start    = in_acc;
  assign mod_req.dividend = (in_ch.kind == sacl_pkg::KIND_INVAL) ? in_ch.block_number
                                                                  : in_ch.address;

  sacl_mod #(
    .SETS(SETS)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mod_req),
    .divisor  (eff_sets),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r    <= in_ch.kind;
      addr_r    <= in_ch.address;
      way_num_r <= in_ch.way_number;
    end
    if (mod_done) begin
      set_r <= mod_rem;
    end
  end

  // ---------------------------------------------------------------- tag / stamp RAM
  // Every write carries both tag and stamp; a stamp comparison only decides the way once all
  // scanned ways of the set are valid, so each stamp that decides has been written.
  sacl_ram #(
    .WIDTH(RAM_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr({set_r, upd_way}),
    .wdata({addr_r, time_r}),
    .raddr({set_r, scan_cnt_r[WAY_W-1:0]}),
    .rdata(ram_rdata)
  );

  assign rd_tag   = ram_rdata[RAM_W-1:sacl_pkg::TIME_W];
  assign rd_stamp = ram_rdata[sacl_pkg::TIME_W-1:0];

  // ---------------------------------------------------------------- way scan
  // read of way k issues at scan count k, its data is checked at count k+1
  always_comb begin
    chk_way   = WAY_W'(scan_cnt_r - 1'b1);
    chk_valid = valid_r[set_r][chk_way];
  end

  always_ff @(posedge clk) begin
    if (state_r == sacl_pkg::ST_DIV) begin
      scan_cnt_r  <= '0;
      hit_r       <= 1'b0;
      inv_found_r <= 1'b0;
    end else if (state_r == sacl_pkg::ST_SCAN) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
      if (scan_cnt_r != '0) begin
        if (!hit_r && chk_valid && (rd_tag == addr_r)) begin
          hit_r     <= 1'b1;
          hit_way_r <= chk_way;
        end
        if (!inv_found_r && !chk_valid) begin
          inv_found_r <= 1'b1;
          inv_way_r   <= chk_way;
        end
        // strict compare keeps the lower way on a tie
        if ((chk_way == '0) || (rd_stamp < best_stamp_r)) begin
          best_way_r   <= chk_way;
          best_stamp_r <= rd_stamp;
        end
      end
    end
  end

  // ---------------------------------------------------------------- update
  always_comb begin
    priority if (hit_r) begin
      upd_way     = hit_way_r;
      upd_outcome = sacl_pkg::OC_HIT;
    end else if (inv_found_r) begin
      upd_way     = inv_way_r;
      upd_outcome = sacl_pkg::OC_FILL;
    end else begin
      upd_way     = best_way_r;
      upd_outcome = sacl_pkg::OC_REPLACE;
    end
  end

  assign inval_ok = (32'(way_num_r) < 32'(eff_ways));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        valid_r[s] <= '0;
      end
      time_r <= sacl_pkg::TIME_W'(1);
    end else begin
      if (state_r == sacl_pkg::ST_UPDATE) begin
        valid_r[set_r][upd_way] <= 1'b1;
        if (time_r != '1) begin
          time_r <= time_r + 1'b1;
        end
      end else if ((state_r == sacl_pkg::ST_INVAL) && inval_ok) begin
        valid_r[set_r][WAY_W'(way_num_r)] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sacl_pkg::ST_UPDATE) begin
      res_outcome_r <= upd_outcome;
      res_way_r     <= sacl_pkg::WAY_NUM_W'(upd_way);
    end else if (state_r == sacl_pkg::ST_INVAL) begin
      res_outcome_r <= inval_ok ? sacl_pkg::OC_INVAL : sacl_pkg::OC_IGNORED;
      res_way_r     <= way_num_r;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_outcome_r <= res_outcome_r;
      out_way_r     <= res_way_r;
      out_set_r     <= sacl_pkg::SET_IDX_W'(set_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.outcome     = out_outcome_r;
  assign out_ch.way_touched = out_way_r;
  assign out_ch.set_index   = out_set_r;

  // ---------------------------------------------------------------- checks
  property p_acc_to_div;
    @(posedge clk) disable iff (!rst_n) in_acc |=> (state_r == sacl_pkg::ST_DIV);
  endproperty
  a_acc_to_div: assert property (p_acc_to_div) else $error("accepted word did not start");

  property p_time_adv;
    @(posedge clk) disable iff (!rst_n)
      (state_r == sacl_pkg::ST_UPDATE) && (time_r != '1) |=> (time_r == $past(time_r) + 1'b1);
  endproperty
  a_time_adv: assert property (p_time_adv) else $error("time counter did not advance");

  property p_time_hold;
    @(posedge clk) disable iff (!rst_n)
      (state_r != sacl_pkg::ST_UPDATE) |=> $stable(time_r);
  endproperty
  a_time_hold: assert property (p_time_hold) else $error("time counter moved outside update");

  property p_done_in_div;
    @(posedge clk) disable iff (!rst_n) mod_done |-> (state_r == sacl_pkg::ST_DIV);
  endproperty
  a_done_in_div: assert property (p_done_in_div) else $error("modulo done outside divide");

  property p_hit_set_valid;
    @(posedge clk) disable iff (!rst_n)
      (state_r == sacl_pkg::ST_UPDATE) |=> valid_r[$past(set_r)][$past(upd_way)];
  endproperty
  a_hit_set_valid: assert property (p_hit_set_valid) else $error("updated way not valid");

endmodule

>>> sv/sacl_ram.sv
// sacl_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sacl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/sacl_mod.sv
// sacl_mod: iterative restoring modulo unit, 32-bit dividend by a small divisor.
// Depends on sacl_pkg (mod_req_t, ADDR_W, DIV_STEP_BITS).
`timescale 1ns / 1ps

module sacl_mod #(
  parameter int SETS = sacl_pkg::SETS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  sacl_pkg::mod_req_t                         req,
  input  logic [$clog2(SETS+1)-1:0]                  divisor,
  output logic                                       done,
  output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] remainder
);

  localparam int DV_W     = $clog2(SETS + 1);
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int N_CYC    = sacl_pkg::ADDR_W / sacl_pkg::DIV_STEP_BITS;
  localparam int CNT_W    = $clog2(N_CYC);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_CYC - 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [DV_W-1:0]             rem_r;
  logic [DV_W-1:0]             dvs_r;
  logic [sacl_pkg::ADDR_W-1:0] dvd_r;
  logic [DV_W-1:0]             rem_n;

  // one restoring step: shift in a bit, subtract if it fits
  function automatic logic [DV_W-1:0] mod_step(input logic [DV_W-1:0] r, input logic b,
                                                 input logic [DV_W-1:0] d);
    logic [DV_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[DV_W-1:0];
  endfunction

  // DIV_STEP_BITS dividend bits per cycle, MSB first
  always_comb begin
    rem_n = rem_r;
    for (int i = 0; i < sacl_pkg::DIV_STEP_BITS; i++) begin
      rem_n = mod_step(rem_n, dvd_r[sacl_pkg::ADDR_W-1-i], dvs_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      dvd_r <= req.dividend;
    end else if (busy_r) begin
      rem_r <= rem_n;
      dvd_r <= dvd_r << sacl_pkg::DIV_STEP_BITS;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[SET_W-1:0];

  property p_start_idle;
    @(posedge clk) disable iff (!rst_n) req.start |-> !busy_r;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("modulo restarted while busy");

  property p_rem_below;
    @(posedge clk) disable iff (!rst_n) done_r |-> (rem_r < dvs_r);
  endproperty
  a_rem_below: assert property (p_rem_below) else $error("remainder not below divisor");

  property p_done_pulse;
    @(posedge clk) disable iff (!rst_n) done_r |=> !done_r;
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("done held more than one cycle");

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for the set-associative LRU tag store.
// Depends on sacl_pkg, sacl_in_if, sacl_out_if, sacl_cfg_if and set_assoc_cache_lru_tags.
// Directed table first, then random phases under changing way/set settings.
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_PHASES      = 10;
  localparam int WORDS_PER_PHASE = 155;
  localparam int MAX_GAP         = 16;
  localparam int HOLD_CYCLES     = 400;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int POOL_SIZE       = 10;
  localparam int LINES           = sacl_pkg::WAYS_DEF * sacl_pkg::SETS_DEF;

  typedef struct packed {
    sacl_pkg::outcome_t             outcome;
    logic [sacl_pkg::WAY_NUM_W-1:0] way;
    logic [sacl_pkg::SET_IDX_W-1:0] set_idx;
  } tag_result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_op_t;

  // config rows: addr carries the write data, blk the register index
  typedef struct {
    row_op_t                        op;
    logic                           kind;
    logic [sacl_pkg::ADDR_W-1:0]    addr;
    logic [sacl_pkg::ADDR_W-1:0]    blk;
    logic [sacl_pkg::WAY_NUM_W-1:0] wnum;
    bit                             fixed;
    tag_result_t                    res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sacl_in_if  in_ch();
  sacl_out_if out_ch();
  sacl_cfg_if cfg_ch();

  set_assoc_cache_lru_tags #(
    .WAYS(sacl_pkg::WAYS_DEF),
    .SETS(sacl_pkg::SETS_DEF)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [sacl_pkg::ADDR_W-1:0]     tag_mem    [LINES];
  bit                              line_valid [LINES];
  logic [sacl_pkg::TIME_W-1:0]     line_stamp [LINES];
  logic [sacl_pkg::TIME_W-1:0]     lru_clock;
  logic [sacl_pkg::WAYS_CFG_W-1:0] ways_reg;
  logic [sacl_pkg::SETS_CFG_W-1:0] sets_reg;

  tag_result_t result_q[$];
  dir_row_t    dir_table[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          hold_req = 1'b0;
  bit          snd_quiet = 1'b0;
  bit          rcv_quiet = 1'b0;

  function automatic int unsigned ways_active();
    if (ways_reg == 0) return 1;
    if (ways_reg > sacl_pkg::WAYS_DEF) return sacl_pkg::WAYS_DEF;
    return ways_reg;
  endfunction

  function automatic int unsigned sets_active();
    if (sets_reg == 0) return 1;
    if (sets_reg > sacl_pkg::SETS_DEF) return sacl_pkg::SETS_DEF;
    return sets_reg;
  endfunction

  function automatic tag_result_t lru_predict(logic kind, logic [sacl_pkg::ADDR_W-1:0] addr,
                                              logic [sacl_pkg::ADDR_W-1:0] blk,
                                              logic [sacl_pkg::WAY_NUM_W-1:0] wnum);
    int unsigned ways, sets, set_no, base, w, best;
    bit done;
    tag_result_t r;
    ways = ways_active();
    sets = sets_active();
    done = 1'b0;
    best = 0;
    r.way = '0;
    r.outcome = sacl_pkg::OC_HIT;
    if (kind == sacl_pkg::KIND_LOOKUP) begin
      set_no = addr % sets;
      base = set_no * sacl_pkg::WAYS_DEF;
      for (w = 0; w < ways && !done; w++) begin
        if (line_valid[base+w] && tag_mem[base+w] == addr) begin
          line_stamp[base+w] = lru_clock;
          r.outcome = sacl_pkg::OC_HIT;
          r.way = sacl_pkg::WAY_NUM_W'(w);
          done = 1'b1;
        end
      end
      for (w = 0; w < ways && !done; w++) begin
        if (!line_valid[base+w]) begin
          r.outcome = sacl_pkg::OC_FILL;
          r.way = sacl_pkg::WAY_NUM_W'(w);
          done = 1'b1;
        end
      end
      if (!done) begin
        // oldest stamp wins, ties stay on the lower way
        for (w = 1; w < ways; w++)
          if (line_stamp[base+w] < line_stamp[base+best]) best = w;
        r.outcome = sacl_pkg::OC_REPLACE;
        r.way = sacl_pkg::WAY_NUM_W'(best);
      end
      if (r.outcome != sacl_pkg::OC_HIT) begin
        tag_mem[base+r.way]    = addr;
        line_stamp[base+r.way] = lru_clock;
        line_valid[base+r.way] = 1'b1;
      end
      if (lru_clock != '1) lru_clock = lru_clock + 1'b1;
    end else begin
      set_no = blk % sets;
      r.way = wnum;
      if (wnum < ways) begin
        line_valid[set_no*sacl_pkg::WAYS_DEF+wnum] = 1'b0;
        r.outcome = sacl_pkg::OC_INVAL;
      end else begin
        r.outcome = sacl_pkg::OC_IGNORED;
      end
    end
    r.set_idx = sacl_pkg::SET_IDX_W'(set_no);
    return r;
  endfunction

  function automatic dir_row_t mk_row(row_op_t op, logic kind, logic [sacl_pkg::ADDR_W-1:0] a,
                                      logic [sacl_pkg::ADDR_W-1:0] b,
                                      logic [sacl_pkg::WAY_NUM_W-1:0] w,
                                      bit fixed, sacl_pkg::outcome_t oc,
                                      logic [sacl_pkg::WAY_NUM_W-1:0] ew,
                                      logic [sacl_pkg::SET_IDX_W-1:0] es);
    dir_row_t r;
    r.op = op;
    r.kind = kind;
    r.addr = a;
    r.blk = b;
    r.wnum = w;
    r.fixed = fixed;
    r.res.outcome = oc;
    r.res.way = ew;
    r.res.set_idx = es;
    return r;
  endfunction

  task automatic report(string field, int got, int want);
    $display("testbench: mismatch on %s: got %0d, expected %0d at %0t", field, got, want,
             $realtime);
    mismatches++;
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_word(logic kind, logic [sacl_pkg::ADDR_W-1:0] addr,
                           logic [sacl_pkg::ADDR_W-1:0] blk,
                           logic [sacl_pkg::WAY_NUM_W-1:0] wnum, int gap, bit fixed,
                           tag_result_t typed);
    tag_result_t r;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.kind         = kind;
    in_ch.address      = addr;
    in_ch.block_number = blk;
    in_ch.way_number   = wnum;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    r = lru_predict(kind, addr, blk, wnum);
    result_q.push_back(fixed ? typed : r);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                           logic [sacl_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid     = 1'b1;
    cfg_ch.reg_index = idx;
    cfg_ch.wr_data   = data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    if (idx == sacl_pkg::CFG_REG_WAYS) ways_reg = data[sacl_pkg::WAYS_CFG_W-1:0];
    else if (idx == sacl_pkg::CFG_REG_SETS) sets_reg = data[sacl_pkg::SETS_CFG_W-1:0];
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // result side
  initial begin
    int stall;
    tag_result_t want;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = rcv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      if (result_q.size() == 0) begin
        report("unexpected word, outcome", out_ch.outcome, -1);
      end else begin
        want = result_q.pop_front();
        if (out_ch.outcome !== want.outcome) report("outcome", out_ch.outcome, want.outcome);
        if (out_ch.way_touched !== want.way) report("way_touched", out_ch.way_touched, want.way);
        if (out_ch.set_index !== want.set_idx)
          report("set_index", out_ch.set_index, want.set_idx);
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus side
  initial begin
    int ph, i, j, pick, gap;
    int unsigned sets, tgt_set;
    int unsigned tgt[3];
    logic [sacl_pkg::ADDR_W-1:0] pool[POOL_SIZE];
    logic [sacl_pkg::ADDR_W-1:0] addr, blk;
    logic [sacl_pkg::WAY_NUM_W-1:0] wnum;
    logic kind;
    logic [sacl_pkg::WAYS_CFG_W-1:0] ways_val;
    logic [sacl_pkg::SETS_CFG_W-1:0] sets_val;
    longint unsigned lim, k;
    tag_result_t none;

    in_ch.valid = 1'b0;
    in_ch.kind = sacl_pkg::KIND_LOOKUP;
    in_ch.address = '0;
    in_ch.block_number = '0;
    in_ch.way_number = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.wr_data = '0;
    none = '{sacl_pkg::OC_HIT, 2'd0, 6'd0};
    foreach (line_valid[n]) begin
      line_valid[n] = 1'b0;
      line_stamp[n] = '0;
    end
    lru_clock = 1;
    ways_reg = sacl_pkg::WAYS_CFG_RST;
    sets_reg = sacl_pkg::SETS_CFG_RST;

    // after reset: 4 ways, 64 sets
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'd0, 32'd0, 2'd0, 1,
                               sacl_pkg::OC_FILL, 2'd0, 6'd0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'd0, 32'd0, 2'd0, 1,
                               sacl_pkg::OC_HIT, 2'd0, 6'd0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'd64, 32'd0, 2'd0, 1,
                               sacl_pkg::OC_FILL, 2'd1, 6'd0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'd128, 32'd0, 2'd0, 1,
                               sacl_pkg::OC_FILL, 2'd2, 6'd0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'd192, 32'd0, 2'd0, 1,
                               sacl_pkg::OC_FILL, 2'd3, 6'd0));
    // way 0 was refreshed by the hit but is still the oldest
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'd256, 32'd0, 2'd0, 1,
                               sacl_pkg::OC_REPLACE, 2'd0, 6'd0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, '1, '1, 2'd3, 1,
                               sacl_pkg::OC_FILL, 2'd0, 6'd63));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_INVAL, '1, 32'd0, 2'd1, 1,
                               sacl_pkg::OC_INVAL, 2'd1, 6'd0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'd64, 32'd0, 2'd0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_INVAL, 32'd0, '1, 2'd3, 1,
                               sacl_pkg::OC_INVAL, 2'd3, 6'd63));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'd0, 32'd0, 2'd0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'hAAAA_AAAA, 32'h5555_5555,
                               2'd2, 0, sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'h5555_5555, 32'hAAAA_AAAA,
                               2'd1, 0, sacl_pkg::OC_HIT, 0, 0));
    // unused register index, no effect
    dir_table.push_back(mk_row(ROW_CFG, 0, 32'hDEAD_BEEF, 32'hFE, 0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_CFG, 0, 32'd2, sacl_pkg::CFG_REG_WAYS, 0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    // way beyond the ways in use
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_INVAL, 32'd0, 32'd5, 2'd3, 1,
                               sacl_pkg::OC_IGNORED, 2'd3, 6'd5));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_INVAL, 32'd0, 32'd5, 2'd2, 1,
                               sacl_pkg::OC_IGNORED, 2'd2, 6'd5));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'd0, 32'd0, 2'd0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_CFG, 0, 32'd1, sacl_pkg::CFG_REG_SETS, 0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'd12345, 32'd0, 2'd0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_INVAL, 32'd0, '1, 2'd0, 1,
                               sacl_pkg::OC_INVAL, 2'd0, 6'd0));
    // zero registers act as one
    dir_table.push_back(mk_row(ROW_CFG, 0, 32'd0, sacl_pkg::CFG_REG_WAYS, 0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_CFG, 0, 32'd0, sacl_pkg::CFG_REG_SETS, 0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'd7, 32'd0, 2'd0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_INVAL, 32'd7, 32'd9, 2'd1, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    // oversized registers clamp to the full geometry
    dir_table.push_back(mk_row(ROW_CFG, 0, '1, sacl_pkg::CFG_REG_WAYS, 0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_CFG, 0, '1, sacl_pkg::CFG_REG_SETS, 0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_LOOKUP, 32'h8000_0000, 32'd0, 2'd0, 0,
                               sacl_pkg::OC_HIT, 0, 0));
    dir_table.push_back(mk_row(ROW_WORD, sacl_pkg::KIND_INVAL, 32'd0, 32'hFFFF_FFC0, 2'd0, 1,
                               sacl_pkg::OC_INVAL, 2'd0, 6'd0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_table[n]) begin
      if (dir_table[n].op == ROW_CFG) begin
        drain_results();
        cfg_write(dir_table[n].blk[sacl_pkg::CFG_IDX_W-1:0], dir_table[n].addr);
      end else begin
        send_word(dir_table[n].kind, dir_table[n].addr, dir_table[n].blk, dir_table[n].wnum,
                  $urandom_range(0, MAX_GAP), dir_table[n].fixed, dir_table[n].res);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      unique case (ph)
        0: begin ways_val = 3'd1; sets_val = 7'd1;   end
        1: begin ways_val = 3'd4; sets_val = 7'd64;  end
        2: begin ways_val = 3'd0; sets_val = 7'd0;   end
        3: begin ways_val = 3'd7; sets_val = 7'd127; end
        4: begin ways_val = 3'd2; sets_val = 7'd64;  end
        default: begin
          ways_val = sacl_pkg::WAYS_CFG_W'($urandom_range(1, 4));
          sets_val = sacl_pkg::SETS_CFG_W'(($urandom_range(0, 3) == 0) ?
                                           $urandom_range(0, 127) : $urandom_range(1, 64));
        end
      endcase
      drain_results();
      cfg_write(sacl_pkg::CFG_REG_WAYS, ($urandom & ~32'h7) | ways_val);
      cfg_write(sacl_pkg::CFG_REG_SETS, ($urandom & ~32'h7F) | sets_val);
      snd_quiet = (ph == 1) || ($urandom_range(0, 3) == 0);
      rcv_quiet = (ph == 1) || ($urandom_range(0, 3) == 0);

      // a few crowded sets so that hits and evictions are common
      sets = sets_active();
      for (j = 0; j < 3; j++) tgt[j] = $urandom_range(0, sets - 1);
      for (j = 0; j < POOL_SIZE; j++) begin
        tgt_set = tgt[j % 3];
        lim = (64'hFFFF_FFFF - tgt_set) / sets;
        k = {$urandom, $urandom} % (lim + 1);
        pool[j] = sacl_pkg::ADDR_W'(tgt_set + sets * k);
      end

      for (i = 0; i < WORDS_PER_PHASE; i++) begin
        if (ph == 5 && i == 20) hold_req = 1'b1;
        if (ph == 7 && i == 70) drain_results();
        pick = $urandom_range(0, 99);
        addr = $urandom;
        blk  = $urandom;
        wnum = sacl_pkg::WAY_NUM_W'($urandom_range(0, 3));
        if (pick < 75) begin
          kind = sacl_pkg::KIND_LOOKUP;
          addr = pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick < 83) begin
          kind = sacl_pkg::KIND_LOOKUP;
        end else begin
          kind = sacl_pkg::KIND_INVAL;
          if ($urandom_range(0, 1)) blk = pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        gap = snd_quiet ? 0 : $urandom_range(0, MAX_GAP);
        send_word(kind, addr, blk, wnum, gap, 1'b0, none);
      end
    end

    in_ch.valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> set_assoc_cache_lru_tags.f
sv/sacl_pkg.sv
sv/sacl_in_if.sv
sv/sacl_out_if.sv
sv/sacl_cfg_if.sv
sv/sacl_ram.sv
sv/sacl_mod.sv
sv/set_assoc_cache_lru_tags.sv
tb/testbench.sv
